@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/sps_pkg.sv @@
// Shared types and constants of the servo pulse angle slew block.
// Depends on nothing.
package sps_pkg;

  localparam int TIMESTAMP_BITS_DEF = 63;
  localparam int WORD_BITS          = 17;
  localparam int WIDTH_US_BITS      = 16;
  localparam int ANGLE_BITS         = 8;
  localparam int CFG_INDEX_BITS     = 8;
  localparam int CFG_DATA_BITS      = 8;
  localparam int ELAPSED_BITS       = 22;

  localparam logic [ANGLE_BITS-1:0]    ANGLE_CEIL        = 8'd180;
  localparam logic [ANGLE_BITS-1:0]    SLEW_STEP_RESET   = 8'd5;
  localparam logic [ANGLE_BITS-1:0]    ANGLE_LIMIT_RESET = 8'd180;
  localparam logic [ELAPSED_BITS-1:0]  ELAPSED_SAT       = 22'd4000000;
  localparam logic [ELAPSED_BITS-1:0]  NS_PER_MS         = 22'd1000000;
  localparam logic [WIDTH_US_BITS-1:0] US_PER_MS         = 16'd1000;

  // floor(y / 15625) = (y * NS_RECIP) >> NS_SHIFT for y < 2**23
  localparam logic [23:0] NS_RECIP = 24'd8796094;
  localparam int          NS_SHIFT = 37;
  // floor(y / 25) = (y * US_RECIP) >> US_SHIFT for y < 2**18
  localparam logic [18:0] US_RECIP = 19'd335545;
  localparam int          US_SHIFT = 23;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SLEW_STEP   = 8'd0,
    REG_ANGLE_LIMIT = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] slew_step;
    logic [ANGLE_BITS-1:0] angle_limit;
  } cfg_t;

endpackage

@@ hw/rtl/sps_if.sv @@
// Channel interfaces of the servo pulse angle slew block: events, results, config.
// Depends on sps_pkg.
interface sps_evt_if #(
  parameter int TIMESTAMP_BITS = sps_pkg::TIMESTAMP_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [sps_pkg::WORD_BITS-1:0]  level_word;
  logic [TIMESTAMP_BITS-1:0]      timestamp_ns;

  modport source (output valid, level_word, timestamp_ns, input ready);
  modport sink   (input valid, level_word, timestamp_ns, output ready);
endinterface

interface sps_res_if;
  logic                           valid;
  logic                           ready;
  logic [sps_pkg::ANGLE_BITS-1:0] angle;
  logic [sps_pkg::ANGLE_BITS-1:0] target_angle;
  logic                           angle_changed;
  logic                           event_taken;

  modport source (output valid, angle, target_angle, angle_changed, event_taken,
                  input ready);
  modport sink   (input valid, angle, target_angle, angle_changed, event_taken,
                  output ready);
endinterface

interface sps_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sps_pkg::CFG_INDEX_BITS-1:0] index;
  logic [sps_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/sps_cfg_regs.sv @@
// Configuration registers: slew step and angle limit.
// Depends on sps_pkg and sps_cfg_if.
module sps_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  sps_cfg_if.sink        cfg,
  output sps_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.slew_step   <= sps_pkg::SLEW_STEP_RESET;
      regs.angle_limit <= sps_pkg::ANGLE_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        sps_pkg::REG_SLEW_STEP:   regs.slew_step   <= cfg.data;
        sps_pkg::REG_ANGLE_LIMIT: regs.angle_limit <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/sps_target.sv @@
// Target angle from the pulse that just ended, commanded or measured, clamped.
// Depends on sps_pkg.
module sps_target #(
  parameter int TIMESTAMP_BITS = sps_pkg::TIMESTAMP_BITS_DEF
) (
  input  logic [sps_pkg::WORD_BITS-1:0]  last_word,
  input  logic [TIMESTAMP_BITS-1:0]      last_edge_time,
  input  logic [TIMESTAMP_BITS-1:0]      now,
  input  logic [sps_pkg::ANGLE_BITS-1:0] angle_limit,
  output logic [sps_pkg::ANGLE_BITS-1:0] target
);

  localparam logic [TIMESTAMP_BITS-1:0] SAT_TS = TIMESTAMP_BITS'(sps_pkg::ELAPSED_SAT);

  logic [TIMESTAMP_BITS-1:0]          elapsed;
  logic [sps_pkg::ELAPSED_BITS-1:0]   elapsed_sat;
  logic [sps_pkg::ELAPSED_BITS-1:0]   ns_excess;
  logic [28:0]                        ns_scaled;
  logic [46:0]                        ns_prod;
  logic [sps_pkg::WIDTH_US_BITS-1:0]  width_us;
  logic [sps_pkg::WIDTH_US_BITS-1:0]  us_excess;
  logic [19:0]                        us_scaled;
  logic [36:0]                        us_prod;
  logic [13:0]                        deg;
  logic [sps_pkg::ANGLE_BITS-1:0]     lim;

  always_comb begin
    elapsed     = (now >= last_edge_time) ? now - last_edge_time : '0;
    elapsed_sat = (elapsed > SAT_TS) ? sps_pkg::ELAPSED_SAT
                                     : elapsed[sps_pkg::ELAPSED_BITS-1:0];
    ns_excess   = (elapsed_sat > sps_pkg::NS_PER_MS) ? elapsed_sat - sps_pkg::NS_PER_MS : '0;
    ns_scaled   = (29'(ns_excess) << 6) + (29'(ns_excess) << 4) + (29'(ns_excess) << 3)
                + (29'(ns_excess) << 1);
    ns_prod     = 47'(ns_scaled[28:6]) * 47'(sps_pkg::NS_RECIP);

    width_us    = last_word[sps_pkg::WORD_BITS-1:1];
    us_excess   = (width_us > sps_pkg::US_PER_MS) ? width_us - sps_pkg::US_PER_MS : '0;
    us_scaled   = (20'(us_excess) << 3) + 20'(us_excess);
    us_prod     = 37'(us_scaled[19:2]) * 37'(sps_pkg::US_RECIP);

    if (width_us != '0) begin
      deg = us_prod[36:sps_pkg::US_SHIFT];
    end else begin
      deg = 14'(ns_prod[46:sps_pkg::NS_SHIFT]);
    end

    lim    = (angle_limit > sps_pkg::ANGLE_CEIL) ? sps_pkg::ANGLE_CEIL : angle_limit;
    target = (deg > 14'(lim)) ? lim : deg[sps_pkg::ANGLE_BITS-1:0];
  end

endmodule

@@ hw/rtl/sps_slew.sv @@
// Slew limiter: move the current angle toward the target by at most one step.
// Depends on sps_pkg.
module sps_slew (
  input  logic [sps_pkg::ANGLE_BITS-1:0] current,
  input  logic [sps_pkg::ANGLE_BITS-1:0] target,
  input  logic [sps_pkg::ANGLE_BITS-1:0] step,
  output logic [sps_pkg::ANGLE_BITS-1:0] next
);

  always_comb begin
    if (target > current && (target - current) > step) begin
      next = current + step;
    end else if (current > target && (current - target) > step) begin
      next = current - step;
    end else begin
      next = target;
    end
  end

endmodule

@@ hw/rtl/servo_pulse_angle_slew.sv @@
// Top level of the servo pulse angle slew block: input register, decode, result register.
// Depends on sps_pkg, sps_if, sps_cfg_regs, sps_target and sps_slew.
//
//   channel  dir  payload
//   evt      in   level_word, timestamp_ns
//   res      out  angle, target_angle, angle_changed, event_taken
//   cfg      in   index, data (slew_step = 0, angle_limit = 1)
//
// One event per cycle while the result is not stalled; an accepted event is registered in the
// input register, decoded, and registered again in the result register.
// State (last word, last edge time, angle) updates as an event leaves the input register.
// A stalled result holds both registers; evt.ready drops only when both are full.
// Reset is synchronous; it clears state and valid flags and loads the config reset values.
module servo_pulse_angle_slew #(
  parameter int TIMESTAMP_BITS = sps_pkg::TIMESTAMP_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sps_evt_if.sink   evt,
  sps_res_if.source res,
  sps_cfg_if.sink   cfg
);

  sps_pkg::cfg_t                  regs;

  logic                           s1_valid;
  logic [sps_pkg::WORD_BITS-1:0]  s1_word;
  logic [TIMESTAMP_BITS-1:0]      s1_time;

  logic [sps_pkg::WORD_BITS-1:0]  last_word;
  logic [TIMESTAMP_BITS-1:0]      last_edge_time;
  logic [sps_pkg::ANGLE_BITS-1:0] current_angle;

  logic                           advance;
  logic                           fire;
  logic                           taken;
  logic                           fall;
  logic                           changed;
  logic [sps_pkg::ANGLE_BITS-1:0] tgt;
  logic [sps_pkg::ANGLE_BITS-1:0] slewed;
  logic [sps_pkg::ANGLE_BITS-1:0] current_angle_next;

  sps_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sps_target #(.TIMESTAMP_BITS(TIMESTAMP_BITS)) u_target (
    .last_word      (last_word),
    .last_edge_time (last_edge_time),
    .now            (s1_time),
    .angle_limit    (regs.angle_limit),
    .target         (tgt)
  );

  sps_slew u_slew (
    .current (current_angle),
    .target  (tgt),
    .step    (regs.slew_step),
    .next    (slewed)
  );

  always_comb begin
    advance            = !res.valid || res.ready;
    fire               = s1_valid && advance;
    taken              = s1_word != last_word;
    fall               = taken && !s1_word[0];
    changed            = fall && (tgt != current_angle);
    current_angle_next = changed ? slewed : current_angle;
  end

  assign evt.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      s1_word <= evt.level_word;
      s1_time <= evt.timestamp_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_word      <= '0;
      last_edge_time <= '0;
      current_angle  <= '0;
    end else if (fire) begin
      current_angle <= current_angle_next;
      if (taken) begin
        last_word      <= s1_word;
        last_edge_time <= s1_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.angle         <= current_angle_next;
      res.target_angle  <= fall ? tgt : '0;
      res.angle_changed <= changed;
      res.event_taken   <= taken;
    end
  end

endmodule

@@ hw/rtl/sps_checker.sv @@
// Port-level checks of the servo pulse angle slew block, bound to the top level.
// Depends on sps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [sps_pkg::ANGLE_BITS-1:0] angle,
  input logic [sps_pkg::ANGLE_BITS-1:0] target_angle,
  input logic                           angle_changed,
  input logic                           event_taken
);

  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(angle) && $stable(target_angle) && $stable(angle_changed) && $stable(event_taken))
  `ASSERT_IMPLY(a_angle_range, clk, rst, res_valid, angle <= sps_pkg::ANGLE_CEIL && target_angle <= sps_pkg::ANGLE_CEIL)
  `ASSERT_IMPLY(a_change_needs_event, clk, rst, res_valid && angle_changed, event_taken)
  `ASSERT_IMPLY(a_idle_no_target, clk, rst, res_valid && !event_taken, target_angle == '0 && !angle_changed)

endmodule

bind servo_pulse_angle_slew sps_checker u_sps_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .angle         (res.angle),
  .target_angle  (res.target_angle),
  .angle_changed (res.angle_changed),
  .event_taken   (res.event_taken)
);
